### rtl/espl_pkg.sv
// Package for the echo sample power level block: types, constants, helpers.
// No dependencies.
package espl_pkg;

  localparam int unsigned CompWidthDef   = 24;
  localparam int unsigned MaxCompDef     = 7;
  localparam int unsigned IndexWidthDef  = 16;
  localparam int unsigned CfgAddrWidth   = 4;
  localparam int unsigned LogFracBits    = 16;
  localparam logic [25:0] TenLog10Two    = 26'd50504453;

  localparam logic [CfgAddrWidth-1:0] RegCount  = 4'h0;
  localparam logic [CfgAddrWidth-1:0] RegStep   = 4'h4;
  localparam logic [CfgAddrWidth-1:0] RegGain   = 4'h8;
  localparam logic [CfgAddrWidth-1:0] RegAbsorb = 4'hC;

  typedef struct packed {
    logic signed [CompWidthDef-1:0] component_re;
    logic signed [CompWidthDef-1:0] component_im;
    logic [IndexWidthDef-1:0]       sample_index;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] level_db;
    logic [15:0]        out_sample_index;
    logic               near_range;
  } out_req_t;

  typedef struct packed {
    logic [2:0]         count;
    logic [19:0]        step;
    logic signed [15:0] gain;
    logic [15:0]        absorb;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic accum;      // add the request into the sums
    logic finish;     // latch index, compute range and power
    logic log_start;  // start log2 of the selected operand
    logic log_sel_r;  // 0: power, 1: range
    logic add_pow;    // fold power log into total
    logic add_rng;    // fold range log into total
    logic emit;       // round, saturate, load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic complete;   // this request finishes a sample
    logic log_done;
    logic near;       // range of the current sample is below one metre
  } dp_sts_t;

endpackage

### rtl/espl_log2.sv
// Iterative log2 unit: Q.16 result, one squaring step per cycle.
// Depends on espl_pkg.
module espl_log2 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  output logic        done_o,
  output logic [21:0] log_o
);
  import espl_pkg::*;

  logic [5:0]  n_q, n_d;
  logic [32:0] m_q, m_d;
  logic [15:0] f_q, f_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  lead;
  logic [65:0] sq;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 64; i++) begin
      if (x_i[i]) lead = 6'(i);
    end
  end

  assign sq = 66'(m_q) * 66'(m_q);

  always_comb begin
    n_d = n_q; m_d = m_q; f_d = f_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      n_d    = lead;
      m_d    = (lead >= 6'd31) ? 33'(x_i >> (lead - 6'd31)) : 33'(x_i << (6'd31 - lead));
      f_d    = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sq[65:31] >= 35'h100000000) begin
        m_d = 33'(sq[65:32]);
        f_d = {f_q[14:0], 1'b1};
      end else begin
        m_d = 33'(sq[65:31]);
        f_d = {f_q[14:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(LogFracBits - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    m_q <= m_d;
    f_q <= f_d;
  end

  assign done_o = done_q;
  assign log_o  = {n_q, f_q};
endmodule

### rtl/espl_datapath.sv
// Datapath: complex accumulation, range, power, dB sum and output register.
// Depends on espl_pkg and espl_log2.
module espl_datapath #(
  parameter int unsigned MaxComp = espl_pkg::MaxCompDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  espl_pkg::in_req_t  in_i,
  input  espl_pkg::cfg_t    cfg_i,
  input  espl_pkg::dp_cmd_t cmd_i,
  output espl_pkg::dp_sts_t sts_o,
  output espl_pkg::out_req_t out_o
);
  import espl_pkg::*;

  logic signed [26:0] sum_re_q, sum_im_q, nre, nim;
  logic [2:0]  cnt_q, need;
  logic [15:0] idx_q;
  logic [35:0] r_q;
  logic        near_q, zero_q;
  logic [26:0] a, b;
  logic [63:0] p_q;
  logic signed [47:0] total_q;
  logic [21:0] lg;
  logic        lg_done;
  logic signed [48:0] prod;
  logic [51:0] absorb;
  logic signed [47:0] rnd;
  logic signed [39:0] q;
  out_req_t out_q;

  always_comb begin
    need = cfg_i.count;
    if (need == 3'd0) need = 3'd1;
    if (need > 3'(MaxComp)) need = 3'(MaxComp);
  end

  assign nre = sum_re_q + 27'(in_i.component_re);
  assign nim = sum_im_q + 27'(in_i.component_im);
  assign sts_o.complete = (cnt_q + 3'd1) >= need;
  assign sts_o.log_done = lg_done;
  assign sts_o.near     = near_q;
  assign a = nre[26] ? 27'(-nre) : 27'(nre);
  assign b = nim[26] ? 27'(-nim) : 27'(nim);

  espl_log2 u_log2 (
    .clk_i, .rst_ni,
    .start_i(cmd_i.log_start),
    .x_i    (cmd_i.log_sel_r ? 64'(r_q) : p_q),
    .done_o (lg_done),
    .log_o  (lg)
  );

  // power log times 10log10(2), or range log minus 20 times 20log10(2)
  always_comb begin
    if (cmd_i.add_rng)
      prod = 49'((49'(signed'({1'b0, lg})) - 49'(20 * 65536)) * 49'(TenLog10Two) * 49'sd2);
    else
      prod = 49'(49'(signed'({1'b0, lg})) * 49'(TenLog10Two));
  end

  assign absorb = 52'(r_q) * 52'(cfg_i.absorb);
  assign rnd = total_q >= 0 ? ((total_q + 48'sd128) >>> 8) : -((-total_q + 48'sd127) >>> 8);
  assign q = 40'(rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_re_q <= '0;
      sum_im_q <= '0;
      cnt_q    <= '0;
    end else if (cmd_i.accum) begin
      if (sts_o.complete) begin
        sum_re_q <= '0;
        sum_im_q <= '0;
        cnt_q    <= '0;
      end else begin
        sum_re_q <= nre;
        sum_im_q <= nim;
        cnt_q    <= cnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      idx_q   <= in_i.sample_index;
      r_q     <= 36'(in_i.sample_index) * 36'(cfg_i.step);
      p_q     <= 64'(a) * 64'(a) + 64'(b) * 64'(b);
      zero_q  <= (a == '0) && (b == '0);
      total_q <= 48'(cfg_i.gain) * 48'sd256;
    end else begin
      if (cmd_i.log_start && cmd_i.log_sel_r) begin
        near_q  <= r_q < 36'h100000;
        total_q <= total_q + 48'(absorb >> 20);
      end
      if (cmd_i.add_pow || cmd_i.add_rng) total_q <= total_q + 48'(prod >>> 24);
    end
    if (cmd_i.emit) begin
      out_q.out_sample_index <= idx_q;
      out_q.near_range       <= near_q;
      if (zero_q || q < -40'sd32768) out_q.level_db <= 16'sh8000;
      else if (q > 40'sd32767)       out_q.level_db <= 16'sh7fff;
      else                           out_q.level_db <= 16'(q);
    end
  end

  assign out_o = out_q;
endmodule

### rtl/espl_ctrl.sv
// Controller state machine: sequences accumulate, two log passes and emit.
// Depends on espl_pkg.
module espl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  espl_pkg::dp_sts_t sts_i,
  output espl_pkg::dp_cmd_t cmd_o
);
  import espl_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StLogP  = 6'b000010,
    StWaitP = 6'b000100,
    StLogR  = 6'b001000,
    StWaitR = 6'b010000,
    StEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q && out_stall_i;
    cmd_o    = '0;
    in_stall_o = (state_q != StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accum = 1'b1;
          if (sts_i.complete) begin
            cmd_o.finish = 1'b1;
            state_d = StLogP;
          end
        end
      end
      StLogP: begin
        cmd_o.log_start = 1'b1;
        state_d = StWaitP;
      end
      StWaitP: begin
        if (sts_i.log_done) begin
          cmd_o.add_pow = 1'b1;
          state_d = StLogR;
        end
      end
      StLogR: begin
        cmd_o.log_start = 1'b1;
        cmd_o.log_sel_r = 1'b1;
        state_d = StWaitR;
      end
      StWaitR: begin
        cmd_o.log_sel_r = 1'b1;
        if (sts_i.log_done) begin
          cmd_o.add_rng = !sts_i.near;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (!ovalid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
endmodule

### rtl/echo_sample_power_level.sv
// Top level of the echo sample power level block: APB registers, controller,
// datapath. Depends on espl_pkg, espl_ctrl, espl_datapath.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_stall_o   | in_req_t (re, im, sample_index)
//  out     | output    | out_valid_o/out_stall_i | out_req_t (level, index, near)
//  cfg     | input     | APB psel/penable        | four registers at 4*i
//
// A request that does not finish a sample is taken in the idle state. One
// that finishes a sample is accepted, then a start and a wait state run for
// each of the two 16-step log2 passes in the shared log unit, then emit,
// before the next request. Reset clears sums, count, FSM, output valid and
// loads the register defaults. A result waits in the output register under
// out_stall_i; the next sample's work proceeds and only stalls at emit.
module echo_sample_power_level #(
  parameter int unsigned MAX_COMPONENTS  = espl_pkg::MaxCompDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  espl_pkg::in_req_t    in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output espl_pkg::out_req_t   out_req_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [espl_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import espl_pkg::*;

  cfg_t    cfg_q;
  dp_cmd_t cmd;
  dp_sts_t sts;
  out_req_t dp_out;

  assign pready = 1'b1;

  // write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count  <= 3'd1;
      cfg_q.step   <= 20'd25166;
      cfg_q.gain   <= '0;
      cfg_q.absorb <= 16'd1311;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        RegCount:  cfg_q.count  <= pwdata[2:0];
        RegStep:   cfg_q.step   <= pwdata[19:0];
        RegGain:   cfg_q.gain   <= pwdata[15:0];
        RegAbsorb: cfg_q.absorb <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegCount:  prdata = 32'(cfg_q.count);
      RegStep:   prdata = 32'(cfg_q.step);
      RegGain:   prdata = 32'(unsigned'(cfg_q.gain));
      RegAbsorb: prdata = 32'(cfg_q.absorb);
      default:   prdata = '0;
    endcase
  end

  espl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i,
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  espl_datapath #(.MaxComp(MAX_COMPONENTS)) u_dp (
    .clk_i, .rst_ni,
    .in_i  (in_req_i),
    .cfg_i (cfg_q),
    .cmd_i (cmd),
    .sts_o (sts),
    .out_o (dp_out)
  );

  assign out_req_o = dp_out;
endmodule
